>>> rtl/core/krls_pkg.sv
// ============================================================================
// krls_pkg
// Shared types, constants and helpers for the keyed record list store.
// ============================================================================
package krls_pkg;

   localparam int RECORD_SLOTS = 16;
   localparam int SLOT_W       = $clog2(RECORD_SLOTS);
   localparam int LINK_W       = $clog2(RECORD_SLOTS + 1);
   localparam int KEY_W        = 64;
   localparam int PAY_W        = 32;
   localparam int REC_W        = KEY_W + PAY_W;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [LINK_W-1:0] link_type;

   // null link: one past the last slot
   localparam link_type NIL_LINK = LINK_W'(RECORD_SLOTS);

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_ERASE = 2'd1,
      FUNC_FIND  = 2'd2,
      FUNC_NEXT  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_W_FREE,
      ST_W_WALK,
      ST_S_WALK,
      ST_E_FIX,
      ST_N_READ,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic     we;
      slot_type waddr;
      link_type wdata;
      slot_type raddr;
   } link_req_type;

   typedef struct packed {
      logic             we;
      slot_type         waddr;
      logic [REC_W-1:0] wdata;
      slot_type         raddr;
   } rec_req_type;

   function automatic logic is_slot(input link_type l);
      return l < NIL_LINK;
   endfunction

   function automatic slot_type to_slot(input link_type l);
      return l[SLOT_W-1:0];
   endfunction

endpackage

>>> rtl/core/krls_if.sv
// ============================================================================
// krls_if
// Valid/ready channels for requests and responses of the record list store.
// ============================================================================
interface krls_req_if;
   import krls_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       func;
   logic [KEY_W-1:0] key;
   logic [PAY_W-1:0] payload;
   logic             from_start;

   modport source (output valid, func, key, payload, from_start, input ready);
   modport sink   (input valid, func, key, payload, from_start, output ready);
endinterface

interface krls_rsp_if;
   import krls_pkg::*;

   logic             valid;
   logic             ready;
   logic             success;
   logic [KEY_W-1:0] found_key;
   logic [PAY_W-1:0] found_payload;

   modport source (output valid, success, found_key, found_payload, input ready);
   modport sink   (input valid, success, found_key, found_payload, output ready);
endinterface

>>> rtl/core/krls_ram.sv
// ============================================================================
// krls_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module krls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/core/krls_link.sv
// ============================================================================
// krls_link
// Link store: RAM plus per-slot written bits; an unwritten slot reads as the
// reset chain (slot i links to i+1, last slot to null).
// ============================================================================
module krls_link (
   input  logic                  clock,
   input  logic                  reset,
   input  krls_pkg::link_req_type link_req,
   output krls_pkg::link_type     link_rd
);
   import krls_pkg::*;

   logic [RECORD_SLOTS-1:0] written_ff;
   logic [RECORD_SLOTS-1:0] written_in;
   logic                    flag_ff;
   slot_type                raddr_ff;
   link_type                ram_rdata;

   krls_ram #(
      .WIDTH (LINK_W),
      .DEPTH (RECORD_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (link_req.we),
      .waddr (link_req.waddr),
      .wdata (link_req.wdata),
      .raddr (link_req.raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      written_in = written_ff;
      if (link_req.we) begin
         written_in[link_req.waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   // flag sampled with the read, so it matches old-data RAM behaviour
   always_ff @(posedge clock) begin
      flag_ff  <= written_ff[link_req.raddr];
      raddr_ff <= link_req.raddr;
   end

   assign link_rd = flag_ff ? ram_rdata : (LINK_W'(raddr_ff) + LINK_W'(1));
endmodule

>>> rtl/core/krls_seq.sv
// ============================================================================
// krls_seq
// Operation sequencer: list heads, list walks, read-modify-write of the link
// and record stores, result holding and response register.
// ============================================================================
module krls_seq (
   input  logic                   clock,
   input  logic                   reset,
   krls_req_if.sink               req_chan,
   krls_rsp_if.source             rsp_chan,
   output krls_pkg::rec_req_type  rec_req,
   input  logic [krls_pkg::REC_W-1:0] rec_rd,
   output krls_pkg::link_req_type link_req,
   input  krls_pkg::link_type     link_rd
);
   import krls_pkg::*;

   state_type        state_ff, state_in;
   func_type         op_ff, op_in;
   logic [KEY_W-1:0] key_ff, key_in;
   slot_type         slot_ff, slot_in;
   slot_type         cur_ff, cur_in;
   link_type         prev_ff, prev_in;
   link_type         lnk_ff, lnk_in;
   link_type         valid_head_ff, valid_head_in;
   link_type         free_head_ff, free_head_in;
   logic             res_ok_ff, res_ok_in;
   logic [KEY_W-1:0] res_key_ff, res_key_in;
   logic [PAY_W-1:0] res_pay_ff, res_pay_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0] rsp_pay_ff, rsp_pay_in;

   logic             out_free;
   logic             key_hit;
   logic [KEY_W-1:0] rec_key;
   logic [PAY_W-1:0] rec_pay;

   assign rec_key  = rec_rd[REC_W-1:PAY_W];
   assign rec_pay  = rec_rd[PAY_W-1:0];
   assign key_hit  = (rec_key == key_ff);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      lnk_in        = lnk_ff;
      valid_head_in = valid_head_ff;
      free_head_in  = free_head_ff;
      res_ok_in     = res_ok_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      link_req      = '0;
      rec_req       = '0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in      = func_type'(req_chan.func);
               key_in     = req_chan.key;
               res_ok_in  = 1'b0;
               res_key_in = '0;
               res_pay_in = '0;
               state_in   = ST_PUSH;
               unique case (func_type'(req_chan.func)) inside
                  FUNC_WRITE: begin
                     if (is_slot(free_head_ff)) begin
                        rec_req.we     = 1'b1;
                        rec_req.waddr  = to_slot(free_head_ff);
                        rec_req.wdata  = {req_chan.key, req_chan.payload};
                        link_req.raddr = to_slot(free_head_ff);
                        slot_in        = to_slot(free_head_ff);
                        state_in       = ST_W_FREE;
                     end
                  end
                  FUNC_NEXT: begin
                     if (is_slot(valid_head_ff)) begin
                        rec_req.raddr  = to_slot(valid_head_ff);
                        link_req.raddr = to_slot(valid_head_ff);
                        cur_in         = to_slot(valid_head_ff);
                        prev_in        = NIL_LINK;
                        state_in       = req_chan.from_start ? ST_N_READ : ST_S_WALK;
                     end
                  end
                  FUNC_ERASE, FUNC_FIND: begin
                     if (is_slot(valid_head_ff)) begin
                        rec_req.raddr  = to_slot(valid_head_ff);
                        link_req.raddr = to_slot(valid_head_ff);
                        cur_in         = to_slot(valid_head_ff);
                        prev_in        = NIL_LINK;
                        state_in       = ST_S_WALK;
                     end
                  end
               endcase
            end
         end

         ST_W_FREE: begin
            // link of the taken slot is the new free head
            free_head_in   = link_rd;
            link_req.we    = 1'b1;
            link_req.waddr = slot_ff;
            link_req.wdata = NIL_LINK;
            if (!is_slot(valid_head_ff)) begin
               valid_head_in = LINK_W'(slot_ff);
               res_ok_in     = 1'b1;
               state_in      = ST_PUSH;
            end else begin
               link_req.raddr = to_slot(valid_head_ff);
               cur_in         = to_slot(valid_head_ff);
               state_in       = ST_W_WALK;
            end
         end

         ST_W_WALK: begin
            if (!is_slot(link_rd)) begin
               link_req.we    = 1'b1;
               link_req.waddr = cur_ff;
               link_req.wdata = LINK_W'(slot_ff);
               res_ok_in      = 1'b1;
               state_in       = ST_PUSH;
            end else begin
               cur_in         = to_slot(link_rd);
               link_req.raddr = to_slot(link_rd);
            end
         end

         ST_S_WALK: begin
            if (key_hit) begin
               unique case (op_ff)
                  FUNC_ERASE: begin
                     link_req.we    = 1'b1;
                     link_req.waddr = cur_ff;
                     link_req.wdata = free_head_ff;
                     lnk_in         = link_rd;
                     state_in       = ST_E_FIX;
                  end
                  FUNC_FIND: begin
                     res_ok_in  = 1'b1;
                     res_key_in = rec_key;
                     res_pay_in = rec_pay;
                     state_in   = ST_PUSH;
                  end
                  FUNC_NEXT: begin
                     if (is_slot(link_rd)) begin
                        rec_req.raddr = to_slot(link_rd);
                        state_in      = ST_N_READ;
                     end else begin
                        state_in = ST_PUSH;
                     end
                  end
                  default: begin
                     state_in = ST_PUSH;
                  end
               endcase
            end else if (is_slot(link_rd)) begin
               prev_in        = LINK_W'(cur_ff);
               cur_in         = to_slot(link_rd);
               rec_req.raddr  = to_slot(link_rd);
               link_req.raddr = to_slot(link_rd);
            end else begin
               state_in = ST_PUSH;
            end
         end

         ST_E_FIX: begin
            // bypass the erased record, then push it on the free list
            if (is_slot(prev_ff)) begin
               link_req.we    = 1'b1;
               link_req.waddr = to_slot(prev_ff);
               link_req.wdata = lnk_ff;
            end else begin
               valid_head_in = lnk_ff;
            end
            free_head_in = LINK_W'(cur_ff);
            res_ok_in    = 1'b1;
            state_in     = ST_PUSH;
         end

         ST_N_READ: begin
            res_ok_in  = 1'b1;
            res_key_in = rec_key;
            res_pay_in = rec_pay;
            state_in   = ST_PUSH;
         end

         ST_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_key_in   = res_key_ff;
               rsp_pay_in   = res_pay_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_head_ff <= NIL_LINK;
         free_head_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_head_ff <= valid_head_in;
         free_head_ff  <= free_head_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      slot_ff    <= slot_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      lnk_ff     <= lnk_in;
      res_ok_ff  <= res_ok_in;
      res_key_ff <= res_key_in;
      res_pay_ff <= res_pay_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_key_ff <= rsp_key_in;
      rsp_pay_ff <= rsp_pay_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.success       = rsp_ok_ff;
   assign rsp_chan.found_key     = rsp_key_ff;
   assign rsp_chan.found_payload = rsp_pay_ff;

   // the valid and free list heads never name the same slot
   a_heads_disjoint: assert property (@(posedge clock) disable iff (reset)
      (is_slot(valid_head_ff) && is_slot(free_head_ff)) |->
         (valid_head_ff != free_head_ff))
      else $error("valid and free list share a head slot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer idle after accepting a transaction");

   a_full_fails: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && (req_chan.func == FUNC_WRITE) &&
       !is_slot(free_head_ff)) |=> (state_ff == ST_PUSH && !res_ok_ff))
      else $error("write to a full pool did not fail at once");

   a_push_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not moved to the response register");
endmodule

>>> rtl/core/keyed_record_list_store_top.sv
// ============================================================================
// keyed_record_list_store_top
// Pool of record slots kept as a free list and an ordered valid list.
// ============================================================================
// Usage
//   req_chan (sink): one transaction per operation - func (write, erase,
//     find, next), 64-bit key, 32-bit payload (write only) and from_start
//     (next only). Accepted on a clock edge with valid and ready high.
//   rsp_chan (source): exactly one transaction per request, in order:
//     success, found_key and found_payload (zero unless a record is shown).
// Timing
//   One request in flight; ready is high only while the sequencer is idle.
//   Each list step is one read of the link RAM and, for lookups, of the
//   record RAM. Find, erase and next walk the valid list from its head
//   until the key hits or the list ends; erase then unlinks the record and
//   next reads the successor's record. Next from the start reads the head
//   record. Write takes the free head and walks to the valid list's tail.
//   Empty-list lookups and full-pool writes go straight to the response.
//   Ready rises again in the cycle that the response turns valid.
// Reset
//   Synchronous, active high: valid list empty, free list is slot 0, 1, ...
//   in order. Link entries fall back to that chain until first written.
// Back-pressure
//   A response waiting on rsp_chan does not block a new request; the next
//   result is held internally until the response register drains.
// ============================================================================
module keyed_record_list_store_top (
   input  logic       clock,
   input  logic       reset,
   krls_req_if.sink   req_chan,
   krls_rsp_if.source rsp_chan
);
   import krls_pkg::*;

   rec_req_type      rec_req;
   link_req_type     link_req;
   logic [REC_W-1:0] rec_rd;
   link_type         link_rd;

   // sequencer: heads, walks, result hold and response register
   krls_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .rec_req  (rec_req),
      .rec_rd   (rec_rd),
      .link_req (link_req),
      .link_rd  (link_rd)
   );

   // link store with reset-chain fallback
   krls_link u_link (
      .clock    (clock),
      .reset    (reset),
      .link_req (link_req),
      .link_rd  (link_rd)
   );

   // record store: {key, payload}, contents undefined until written
   krls_ram #(
      .WIDTH (REC_W),
      .DEPTH (RECORD_SLOTS)
   ) u_rec_ram (
      .clock (clock),
      .we    (rec_req.we),
      .waddr (rec_req.waddr),
      .wdata (rec_req.wdata),
      .raddr (rec_req.raddr),
      .rdata (rec_rd)
   );
endmodule
